@@ rtl/core/pemnf_pkg.sv @@
// Shared constants, types and codes of the pad energy mean and neighbor fill block.
package pemnf_pkg;

  // Grid geometry and field widths
  localparam int SECTOR_COUNT     = 6;
  localparam int ROW_COUNT        = 90;
  localparam int COL_COUNT        = 92;
  localparam int ENERGY_FRAC_BITS = 12;

  localparam int SECTOR_W = 3;
  localparam int ROW_W    = 7;
  localparam int COL_W    = 7;
  localparam int ENERGY_W = 24;
  localparam int EST_W    = 25;
  localparam int SRC_W    = 4;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 16;

  localparam int PAD_TOTAL = SECTOR_COUNT * ROW_COUNT * COL_COUNT;
  localparam int ADDR_W    = $clog2(PAD_TOTAL);

  // Linear pad index before range checks; holds any field pattern
  localparam int BASE_MAX = (2**SECTOR_W - 1) * ROW_COUNT * COL_COUNT
                          + (2**ROW_W - 1) * COL_COUNT + (2**COL_W - 1);
  localparam int BASE_W   = $clog2(BASE_MAX + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic REQ_ACCUMULATE = 1'b0;
  localparam logic REQ_ESTIMATE   = 1'b1;

  // Estimate source codes
  localparam logic [SRC_W-1:0] SRC_DIRECT   = 4'd0;
  localparam logic [SRC_W-1:0] SRC_OWN      = 4'd1;
  localparam logic [SRC_W-1:0] SRC_LR_AVG   = 4'd2;
  localparam logic [SRC_W-1:0] SRC_UD_AVG   = 4'd3;
  localparam logic [SRC_W-1:0] SRC_LEFT     = 4'd4;
  localparam logic [SRC_W-1:0] SRC_RIGHT    = 4'd5;
  localparam logic [SRC_W-1:0] SRC_LR2_AVG  = 4'd6;
  localparam logic [SRC_W-1:0] SRC_UP_EXT   = 4'd7;
  localparam logic [SRC_W-1:0] SRC_DOWN_EXT = 4'd8;
  localparam logic [SRC_W-1:0] SRC_RIGHT2   = 4'd9;
  localparam logic [SRC_W-1:0] SRC_LEFT2    = 4'd10;
  localparam logic [SRC_W-1:0] SRC_NONE     = 4'd11;

  // Queued request, classified by the front
  typedef struct packed {
    logic                is_est;
    logic [SECTOR_W-1:0] sector;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [ENERGY_W-1:0] energy;
    logic [BASE_W-1:0]   base;
  } pemnf_entry_t;

endpackage

@@ rtl/core/pemnf_front.sv @@
// Front: accepts requests, computes the pad index and drops no-op accumulates.
module pemnf_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [pemnf_pkg::SECTOR_W-1:0] sector_i,
  input  logic [pemnf_pkg::ROW_W-1:0]   pad_row_i,
  input  logic [pemnf_pkg::COL_W-1:0]   pad_col_i,
  input  logic [pemnf_pkg::ENERGY_W-1:0] energy_value_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output pemnf_pkg::pemnf_entry_t       q_entry_o
);
  import pemnf_pkg::*;

  logic in_grid;
  logic keep;

  // Range check of the pad itself
  assign in_grid = (32'(sector_i) < SECTOR_COUNT) && (32'(pad_row_i) < ROW_COUNT) &&
                   (32'(pad_col_i) < COL_COUNT);

  // Accumulates of zero energy or outside the grid change nothing
  assign keep = (req_type_i == REQ_ESTIMATE) || (in_grid && (energy_value_i != '0));

  always_comb begin
    q_entry_o.is_est = (req_type_i == REQ_ESTIMATE);
    q_entry_o.sector = sector_i;
    q_entry_o.row    = pad_row_i;
    q_entry_o.col    = pad_col_i;
    q_entry_o.energy = energy_value_i;
    q_entry_o.base   = BASE_W'(BASE_W'(sector_i) * BASE_W'(ROW_COUNT * COL_COUNT)
                     + BASE_W'(pad_row_i) * BASE_W'(COL_COUNT) + BASE_W'(pad_col_i));
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

@@ rtl/core/pemnf_fifo.sv @@
// Short request queue between front and back.
module pemnf_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  pemnf_pkg::pemnf_entry_t entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output pemnf_pkg::pemnf_entry_t entry_o,
  output logic                    empty_o
);
  import pemnf_pkg::*;

  pemnf_entry_t         mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0]  count_q;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

@@ rtl/core/pemnf_back.sv @@
// Back: pad table, neighbor reads, shared divider and estimate output register.
module pemnf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  pemnf_pkg::pemnf_entry_t       q_entry_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pemnf_pkg::EST_W-1:0] energy_estimate_o,
  output logic [pemnf_pkg::SRC_W-1:0]   estimate_source_o
);
  import pemnf_pkg::*;

  localparam int NB_COUNT  = 9;
  localparam int NB_W      = $clog2(NB_COUNT + 1);
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int VAL_W     = SUM_W + 3;
  localparam int OFF_W     = BASE_W + 2;
  localparam logic signed [VAL_W-1:0] EST_MAX = VAL_W'((2**(EST_W-1)) - 1);
  localparam logic signed [VAL_W-1:0] EST_MIN = -VAL_W'(2**(EST_W-1));

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_ACC_RD = 8'b0000_0100,
    ST_ACC_WR = 8'b0000_1000,
    ST_EST_RD = 8'b0001_0000,
    ST_DECIDE = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    MODE_NONE, MODE_SINGLE, MODE_AVG, MODE_EXT
  } mode_e;

  state_e                state_q, state_d;
  logic [ADDR_W-1:0]     clr_addr_q;
  pemnf_entry_t          cur_q;
  logic [NB_W-1:0]       k_q;
  logic [NB_COUNT-1:0]   ok_q;
  logic [SUM_W-1:0]      sum_q [NB_COUNT];
  logic [CNT_W-1:0]      cnt_q [NB_COUNT];
  logic [NB_COUNT-1:0]   fill;
  mode_e                 mode_q;
  logic [SRC_W-1:0]      src_q;
  logic [NB_W-1:0]       sel_b_q;
  logic                  second_q;
  logic [STEP_W-1:0]     step_q;
  logic [SUM_W-1:0]      dq_q;
  logic [CNT_W:0]        rem_q;
  logic [CNT_W-1:0]      divisor_q;
  logic [SUM_W-1:0]      mean_a_q, mean_b_q;
  logic                  out_valid_q;
  logic signed [EST_W-1:0] est_q;
  logic [SRC_W-1:0]      srcout_q;

  // Table memory: {sum, count}
  logic [SUM_W+CNT_W-1:0] mem [PAD_TOTAL];
  logic [SUM_W+CNT_W-1:0] rd_q;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [SUM_W+CNT_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // Neighbor k: row/col step and linear offset
  logic signed [2:0]       nb_dr, nb_dc;
  logic signed [OFF_W-1:0] nb_off;
  logic signed [ROW_W+1:0] nb_row;
  logic signed [COL_W+1:0] nb_col;
  logic signed [OFF_W-1:0] nb_lin;
  logic                    nb_ok;

  always_comb begin
    nb_dr  = 3'sd0;
    nb_dc  = 3'sd0;
    nb_off = '0;
    case (k_q)
      4'd1: begin nb_dc = -3'sd1; nb_off = -OFF_W'(1); end
      4'd2: begin nb_dc = 3'sd1;  nb_off = OFF_W'(1); end
      4'd3: begin nb_dr = -3'sd1; nb_off = -OFF_W'(COL_COUNT); end
      4'd4: begin nb_dr = 3'sd1;  nb_off = OFF_W'(COL_COUNT); end
      4'd5: begin nb_dc = -3'sd2; nb_off = -OFF_W'(2); end
      4'd6: begin nb_dc = 3'sd2;  nb_off = OFF_W'(2); end
      4'd7: begin nb_dr = -3'sd2; nb_off = -OFF_W'(2 * COL_COUNT); end
      4'd8: begin nb_dr = 3'sd2;  nb_off = OFF_W'(2 * COL_COUNT); end
      default: begin nb_dr = 3'sd0; end
    endcase
    nb_row = $signed({2'b00, cur_q.row}) + (ROW_W+2)'(nb_dr);
    nb_col = $signed({2'b00, cur_q.col}) + (COL_W+2)'(nb_dc);
    nb_lin = $signed({2'b00, cur_q.base}) + nb_off;
    nb_ok  = (32'(cur_q.sector) < SECTOR_COUNT) &&
             (nb_row >= 0) && (nb_row < (ROW_W+2)'(ROW_COUNT)) &&
             (nb_col >= 0) && (nb_col < (COL_W+2)'(COL_COUNT));
  end

  // Filled pads: in grid and nonzero sum
  always_comb begin
    for (int i = 0; i < NB_COUNT; i++) begin
      fill[i] = ok_q[i] && (sum_q[i] != '0);
    end
  end

  // Divider step: restoring, one quotient bit per cycle
  logic [CNT_W:0]   rem_sh;
  logic             div_ge;
  logic [SUM_W-1:0] div_res;
  assign rem_sh  = {rem_q[CNT_W-1:0], dq_q[SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, divisor_q};
  assign div_res = (divisor_q == '0) ? '0 : dq_q;

  // Final value and saturation
  logic signed [VAL_W-1:0] va, vb, val, val_sat;
  assign va = $signed({3'b000, mean_a_q});
  assign vb = $signed({3'b000, mean_b_q});
  always_comb begin
    case (mode_q)
      MODE_SINGLE: val = va;
      MODE_AVG:    val = (va + vb) >>> 1;
      MODE_EXT:    val = (va <<< 1) - vb;
      default:     val = '0;
    endcase
    if (val > EST_MAX)      val_sat = EST_MAX;
    else if (val < EST_MIN) val_sat = EST_MIN;
    else                    val_sat = val;
  end

  // Accumulate update with saturation
  logic [SUM_W:0]   acc_sum;
  logic [CNT_W-1:0] acc_cnt;
  assign acc_sum = {1'b0, rd_q[SUM_W+CNT_W-1:CNT_W]} + (SUM_W+1)'(cur_q.energy);
  assign acc_cnt = (rd_q[CNT_W-1:0] == '1) ? rd_q[CNT_W-1:0] : rd_q[CNT_W-1:0] + 1'b1;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Memory port control and pop
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q.base[ADDR_W-1:0];
    mem_wdata = {(acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0]), acc_cnt};
    mem_raddr = '0;
    q_pop_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = !(q_entry_i.is_est && (q_entry_i.energy != '0)) || out_free;
        end
      end
      ST_ACC_RD: mem_raddr = cur_q.base[ADDR_W-1:0];
      ST_ACC_WR: mem_we = 1'b1;
      ST_EST_RD: mem_raddr = nb_ok ? nb_lin[ADDR_W-1:0] : '0;
      default: mem_we = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_addr_q == ADDR_W'(PAD_TOTAL - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (q_pop_o && !q_entry_i.is_est) state_d = ST_ACC_RD;
        else if (q_pop_o && (q_entry_i.energy == '0)) state_d = ST_EST_RD;
      end
      ST_ACC_RD: state_d = ST_ACC_WR;
      ST_ACC_WR: state_d = ST_IDLE;
      ST_EST_RD: if (k_q == NB_W'(NB_COUNT)) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_DIV;
      ST_DIV: begin
        // No rule applied: nothing to divide
        if (mode_q == MODE_NONE) begin
          state_d = ST_FIN;
        end else if (step_q == STEP_W'(DIV_STEPS) && (second_q || mode_q == MODE_SINGLE)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if ((state_q == ST_IDLE && q_pop_o && q_entry_i.is_est && q_entry_i.energy != '0) ||
          (state_q == ST_FIN && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          cur_q <= q_entry_i;
          k_q   <= '0;
          if (q_entry_i.is_est && q_entry_i.energy != '0) begin
            est_q    <= EST_W'(q_entry_i.energy);
            srcout_q <= SRC_DIRECT;
          end
        end
      end
      ST_EST_RD: begin
        if (k_q != NB_W'(NB_COUNT)) ok_q[k_q] <= nb_ok;
        if (k_q != '0) begin
          sum_q[k_q - 1'b1] <= rd_q[SUM_W+CNT_W-1:CNT_W];
          cnt_q[k_q - 1'b1] <= rd_q[CNT_W-1:0];
        end
        k_q <= k_q + 1'b1;
      end
      ST_DECIDE: begin
        logic [NB_W-1:0] sa, sb;
        sa = 4'd0;
        sb = 4'd0;
        mode_q <= MODE_SINGLE;
        if (fill[0])                 begin src_q <= SRC_OWN; end
        else if (fill[1] && fill[2]) begin src_q <= SRC_LR_AVG; sa = 4'd1; sb = 4'd2;
                                           mode_q <= MODE_AVG; end
        else if (fill[3] && fill[4]) begin src_q <= SRC_UD_AVG; sa = 4'd3; sb = 4'd4;
                                           mode_q <= MODE_AVG; end
        else if (fill[1])            begin src_q <= SRC_LEFT; sa = 4'd1; end
        else if (fill[2])            begin src_q <= SRC_RIGHT; sa = 4'd2; end
        else if (fill[5] && fill[6]) begin src_q <= SRC_LR2_AVG; sa = 4'd5; sb = 4'd6;
                                           mode_q <= MODE_AVG; end
        else if (fill[3] && fill[7]) begin src_q <= SRC_UP_EXT; sa = 4'd3; sb = 4'd7;
                                           mode_q <= MODE_EXT; end
        else if (fill[4] && fill[8]) begin src_q <= SRC_DOWN_EXT; sa = 4'd4; sb = 4'd8;
                                           mode_q <= MODE_EXT; end
        else if (fill[6])            begin src_q <= SRC_RIGHT2; sa = 4'd6; end
        else if (fill[5])            begin src_q <= SRC_LEFT2; sa = 4'd5; end
        else                         begin src_q <= SRC_NONE; mode_q <= MODE_NONE; end
        sel_b_q   <= sb;
        dq_q      <= sum_q[sa];
        divisor_q <= cnt_q[sa];
        rem_q     <= '0;
        step_q    <= '0;
        second_q  <= 1'b0;
        mean_a_q  <= '0;
        mean_b_q  <= '0;
      end
      ST_DIV: begin
        if (mode_q == MODE_NONE) begin
          step_q <= step_q;
        end else if (step_q != STEP_W'(DIV_STEPS)) begin
          rem_q  <= div_ge ? rem_sh - {1'b0, divisor_q} : rem_sh;
          dq_q   <= {dq_q[SUM_W-2:0], div_ge};
          step_q <= step_q + 1'b1;
        end else if (!second_q) begin
          mean_a_q  <= div_res;
          dq_q      <= sum_q[sel_b_q];
          divisor_q <= cnt_q[sel_b_q];
          rem_q     <= '0;
          step_q    <= '0;
          second_q  <= 1'b1;
        end else begin
          mean_b_q <= div_res;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          est_q    <= val_sat[EST_W-1:0];
          srcout_q <= src_q;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign energy_estimate_o = est_q;
  assign estimate_source_o = srcout_q;

  // Checks
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !q_pop_o) else $error("pop during table clear");
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EST_RD) |-> (k_q <= NB_W'(NB_COUNT))) else $error("neighbor count overrun");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q <= STEP_W'(DIV_STEPS))) else $error("divider overrun");
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_ACC_WR || state_q == ST_CLEAR)) else $error("stray table write");

endmodule

@@ rtl/core/pad_energy_mean_neighbor_fill_top.sv @@
// Top level of the pad energy mean and neighbor fill block.
// Input channel (in_valid_i / in_stall_o) carries one request item: req_type_i
// selects accumulate (adds energy_value_i to the pad's sum and counts a hit) or
// estimate (returns a pad energy). Output channel (out_valid_o / out_stall_i)
// carries one item per estimate: energy_estimate_o and estimate_source_o.
// Accumulates give no output item.
// After reset the table is cleared one pad per cycle, all 49680 pads; items are
// held off (in_stall_o high once the two-entry queue fills) until it is done.
// An estimate with nonzero supplied energy is passed on as the estimate through
// the output register. A table estimate reads nine pads through the single table
// port, picks a rule, then runs the shared bit-serial divider once per mean, once
// or twice. When no rule applies the divider is skipped.
// An accumulate reads, modifies and writes its pad. Items are served one at a
// time in order.
// While the receiver stalls, the finished item stays in the output register;
// the next estimate then waits, and the queue fills and stalls the input.
module pad_energy_mean_neighbor_fill_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [pemnf_pkg::SECTOR_W-1:0] sector_i,
  input  logic [pemnf_pkg::ROW_W-1:0]    pad_row_i,
  input  logic [pemnf_pkg::COL_W-1:0]    pad_col_i,
  input  logic [pemnf_pkg::ENERGY_W-1:0] energy_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [pemnf_pkg::EST_W-1:0] energy_estimate_o,
  output logic [pemnf_pkg::SRC_W-1:0]    estimate_source_o
);
  import pemnf_pkg::*;

  logic         q_push, q_full, q_pop, q_empty;
  pemnf_entry_t q_in, q_out;

  pemnf_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .sector_i       (sector_i),
    .pad_row_i      (pad_row_i),
    .pad_col_i      (pad_col_i),
    .energy_value_i (energy_value_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_in)
  );

  pemnf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  pemnf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_entry_i         (q_out),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .energy_estimate_o (energy_estimate_o),
    .estimate_source_o (estimate_source_o)
  );

endmodule
